FILE: sv/elc_pkg.sv
// shared types, widths and status codes for the edge list canonicaliser
// no dependencies; imported by elc_cmp_unit and edge_list_canonicalizer
package elc_pkg;

	// node and field widths fixed by the transaction formats
	localparam int NODE_W = 4;
	localparam int NODES = 1 << NODE_W;
	localparam int NC_W = 5;
	localparam int KEY_W = 6;
	localparam int STATUS_W = 2;

	// graph limits
	localparam int MAX_NODES = 16;
	localparam int MAX_EDGES_DEF = 32;

	// node count register after reset
	localparam logic [NC_W-1:0] NODE_COUNT_RST = NC_W'(16);

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DISCONNECTED = 2'd3;

	// canonical edge as held in the store, smaller node in the upper half
	typedef struct packed {
		logic [NODE_W-1:0] lo;
		logic [NODE_W-1:0] hi;
	} edge_t;

	// input transaction
	typedef struct packed {
		logic [NODE_W-1:0] first_node;
		logic [NODE_W-1:0] second_node;
		logic              last_edge;
	} edge_item_t;

	// result transaction
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NODE_W-1:0]   low_node;
		logic [NODE_W-1:0]   high_node;
		logic [KEY_W-1:0]    seq_key;
		logic                last_result;
	} result_t;

	// flags from the shared compare and relax unit
	typedef struct packed {
		logic lt;
		logic eq;
		logic changed;
	} cmp_res_t;

endpackage

FILE: sv/elc_cmp_unit.sv
// shared compare and reachability relax unit used by the sort and scan passes of the sequencer
// depends on elc_pkg for edge_t, cmp_res_t and the node width
module elc_cmp_unit import elc_pkg::*; (
	input  edge_t            a,
	input  edge_t            b,
	input  logic [NODES-1:0] reached,
	output cmp_res_t         res,
	output logic [NODES-1:0] reached_next
);

	logic [2*NODE_W-1:0] a_bits;
	logic [2*NODE_W-1:0] b_bits;
	logic                r_lo;
	logic                r_hi;

	assign a_bits = a;
	assign b_bits = b;

	// ordering by low node then high node, and equality for the duplicate scan
	assign res.lt = a_bits < b_bits;
	assign res.eq = a_bits == b_bits;

	// an edge with one reached end marks the other end reached
	assign r_lo = reached[b.lo];
	assign r_hi = reached[b.hi];
	assign res.changed = r_lo ^ r_hi;

	always_comb begin
		reached_next = reached;
		if (r_lo || r_hi) begin
			reached_next[b.lo] = 1'b1;
			reached_next[b.hi] = 1'b1;
		end
	end

endmodule

FILE: sv/edge_list_canonicalizer.sv
// Edge list canonicaliser: edges load one a cycle with busy low. The final edge starts a check
// state, an insertion sort of the elements after the first that shifts larger entries up,
// relaxation passes until nothing changes (the first also finds duplicates), then output
// at one result a cycle, or one error result that ends early.
// Busy falls with the last result, so the next list may load in that cycle; the receiver
// cannot stall. Reset clears control state; the edge store is not cleared and needs no sweep.
module edge_list_canonicalizer import elc_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  edge_item_t      edge_item,
	input  logic            cfg_we,
	input  logic [NC_W-1:0] cfg_wdata,
	output logic            result_valid,
	output result_t         result
);

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CNT_W = $clog2(MAX_EDGES + 1);
	localparam logic [8:0] MAX_NODES_V = 9'(MAX_NODES);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHECK    = 4'd1;
	localparam logic [3:0] S_SORT_LV  = 4'd2;
	localparam logic [3:0] S_SORT_CMP = 4'd3;
	localparam logic [3:0] S_SORT_PUT = 4'd4;
	localparam logic [3:0] S_SCAN_ST  = 4'd5;
	localparam logic [3:0] S_SCAN     = 4'd6;
	localparam logic [3:0] S_OUT_ST   = 4'd7;
	localparam logic [3:0] S_OUT      = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [NC_W-1:0]  node_count_q;
	logic [CNT_W-1:0] loaded_q, loaded_d;
	logic             invalid_q, invalid_d;
	logic             self_q, self_d;
	logic [NODE_W-1:0] max_hi_q, max_hi_d;
	logic [NODES-1:0] reached_q, reached_d;
	logic             changed_q, changed_d;
	logic [AW-1:0]    i_q, i_d;
	logic [AW-1:0]    j_q, j_d;
	edge_t            v_q, v_d;
	edge_t            prev_q, prev_d;
	result_t          result_q, result_d;
	logic             result_valid_q, result_valid_d;

	// edge store
	edge_t            edge_store_q [MAX_EDGES];
	edge_t            rdata_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	edge_t            mem_wdata;
	logic [AW-1:0]    mem_raddr;

	// shared unit
	edge_t            cmp_a;
	cmp_res_t         cmp_res;
	logic [NODES-1:0] reached_next;

	// misc
	logic             accept;
	edge_t            in_edge;
	logic [AW-1:0]    last_idx;
	logic             bad_args;
	logic             connected;

	assign accept = start && !busy;
	assign busy = state_q != S_IDLE;
	assign result = result_q;
	assign result_valid = result_valid_q;
	assign last_idx = AW'(loaded_q - CNT_W'(1));

	// canonical form of the incoming pair
	always_comb begin
		if (edge_item.first_node < edge_item.second_node) begin
			in_edge.lo = edge_item.first_node;
			in_edge.hi = edge_item.second_node;
		end else begin
			in_edge.lo = edge_item.second_node;
			in_edge.hi = edge_item.first_node;
		end
	end

	// argument checks against the node count as it stands now
	assign bad_args = invalid_q || self_q || (node_count_q == '0)
		|| (9'(node_count_q) > MAX_NODES_V)
		|| ({1'b0, max_hi_q} >= node_count_q);

	// every node below the node count must be reached
	always_comb begin
		connected = node_count_q <= NC_W'(NODES);
		for (int k = 0; k < NODES; k++) begin
			if ((NC_W'(k) < node_count_q) && !reached_next[k]) begin
				connected = 1'b0;
			end
		end
	end

	assign cmp_a = (state_q == S_SCAN) ? prev_q : v_q;

	elc_cmp_unit u_cmp (
		.a            (cmp_a),
		.b            (rdata_q),
		.reached      (reached_q),
		.res          (cmp_res),
		.reached_next (reached_next)
	);

	// sequencer next-state and store control
	always_comb begin
		state_d = state_q;
		loaded_d = loaded_q;
		invalid_d = invalid_q;
		self_d = self_q;
		max_hi_d = max_hi_q;
		reached_d = reached_q;
		changed_d = changed_q;
		i_d = i_q;
		j_d = j_q;
		v_d = v_q;
		prev_d = prev_q;
		result_d = result_q;
		result_valid_d = 1'b0;
		mem_we = 1'b0;
		mem_waddr = loaded_q[AW-1:0];
		mem_wdata = in_edge;
		mem_raddr = i_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (loaded_q < CNT_W'(MAX_EDGES)) begin
						mem_we = 1'b1;
						loaded_d = loaded_q + CNT_W'(1);
						if (in_edge.lo == in_edge.hi) begin
							self_d = 1'b1;
						end
						if (in_edge.hi > max_hi_q) begin
							max_hi_d = in_edge.hi;
						end
					end else begin
						invalid_d = 1'b1;
					end
					if (edge_item.last_edge) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (bad_args) begin
					result_d = '{ST_INVALID, '0, '0, '0, 1'b1};
					result_valid_d = 1'b1;
					state_d = S_IDLE;
				end else if (last_idx == '0) begin
					state_d = S_SCAN_ST;
				end else begin
					i_d = AW'(1);
					mem_raddr = AW'(1);
					state_d = S_SORT_LV;
				end
			end
			S_SORT_LV: begin
				v_d = rdata_q;
				j_d = i_q;
				mem_raddr = i_q - AW'(1);
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				mem_we = 1'b1;
				mem_waddr = j_q;
				if (cmp_res.lt) begin
					// shift the larger entry up one place
					mem_wdata = rdata_q;
					if (j_q == AW'(1)) begin
						j_d = '0;
						state_d = S_SORT_PUT;
					end else begin
						j_d = j_q - AW'(1);
						mem_raddr = j_q - AW'(2);
					end
				end else begin
					mem_wdata = v_q;
					if (i_q == last_idx) begin
						state_d = S_SCAN_ST;
					end else begin
						i_d = i_q + AW'(1);
						mem_raddr = i_q + AW'(1);
						state_d = S_SORT_LV;
					end
				end
			end
			S_SORT_PUT: begin
				mem_we = 1'b1;
				mem_waddr = j_q;
				mem_wdata = v_q;
				if (i_q == last_idx) begin
					state_d = S_SCAN_ST;
				end else begin
					i_d = i_q + AW'(1);
					mem_raddr = i_q + AW'(1);
					state_d = S_SORT_LV;
				end
			end
			S_SCAN_ST: begin
				mem_raddr = '0;
				i_d = '0;
				changed_d = 1'b0;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				prev_d = rdata_q;
				reached_d = reached_next;
				changed_d = changed_q || cmp_res.changed;
				if ((i_q != '0) && cmp_res.eq) begin
					result_d = '{ST_DUPLICATE, '0, '0, '0, 1'b1};
					result_valid_d = 1'b1;
					state_d = S_IDLE;
				end else if (i_q == last_idx) begin
					if (changed_q || cmp_res.changed) begin
						state_d = S_SCAN_ST;
					end else if (connected) begin
						state_d = S_OUT_ST;
					end else begin
						result_d = '{ST_DISCONNECTED, '0, '0, '0, 1'b1};
						result_valid_d = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					i_d = i_q + AW'(1);
					mem_raddr = i_q + AW'(1);
				end
			end
			S_OUT_ST: begin
				mem_raddr = '0;
				i_d = '0;
				state_d = S_OUT;
			end
			S_OUT: begin
				result_d.status = ST_OK;
				result_d.low_node = rdata_q.lo;
				result_d.high_node = rdata_q.hi;
				result_d.seq_key = KEY_W'(i_q) + KEY_W'(1);
				result_d.last_result = i_q == last_idx;
				result_valid_d = 1'b1;
				if (i_q == last_idx) begin
					state_d = S_IDLE;
				end else begin
					i_d = i_q + AW'(1);
					mem_raddr = i_q + AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// end of run: back to an empty list
		if (busy && (state_d == S_IDLE)) begin
			loaded_d = '0;
			invalid_d = 1'b0;
			self_d = 1'b0;
			max_hi_d = '0;
			reached_d = NODES'(1);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			node_count_q <= NODE_COUNT_RST;
			loaded_q <= '0;
			invalid_q <= 1'b0;
			self_q <= 1'b0;
			max_hi_q <= '0;
			reached_q <= NODES'(1);
			changed_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			loaded_q <= loaded_d;
			invalid_q <= invalid_d;
			self_q <= self_d;
			max_hi_q <= max_hi_d;
			reached_q <= reached_d;
			changed_q <= changed_d;
			i_q <= i_d;
			j_q <= j_d;
			result_valid_q <= result_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		v_q <= v_d;
		prev_q <= prev_d;
		result_q <= result_d;
	end

	// edge store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			edge_store_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= edge_store_q[mem_raddr];
	end

endmodule
